>>> hw/rtl/tmt_pkg.sv
package tmt_pkg;

  // Field and register widths
  localparam int unsigned WordW  = 32;
  localparam int unsigned RoundW = 3;
  localparam int unsigned CfgIdxW = 2;

  // Reset values of the parameter registers
  localparam logic [WordW-1:0] MaskOneRst = 32'h8f7011ee;
  localparam logic [WordW-1:0] MaskTwoRst = 32'hfc78ff1f;
  localparam logic [WordW-1:0] TempRst    = 32'h3793fdff;

  // Seeding and update constants
  localparam logic [WordW-1:0] MixMult  = 32'd1812433253;
  localparam logic [WordW-1:0] Low31    = 32'h7fffffff;
  localparam logic [RoundW-1:0] MixLast = 3'd7;  // mixing rounds 1..7
  localparam logic [RoundW-1:0] PreLast = 3'd7;  // advances 0..7
  localparam int unsigned Sh0 = 1;
  localparam int unsigned Sh1 = 10;
  localparam int unsigned Sh8 = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgMaskOne = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaskTwo = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTemper  = 2'd2;

  // Input kinds
  localparam logic KindReseed   = 1'b0;
  localparam logic KindGenerate = 1'b1;

  typedef logic [3:0][WordW-1:0] tmt_state_t;

  // Datapath operation selected by the sequencer
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_LOAD = 3'd1,
    OP_MUL  = 3'd2,
    OP_MIX  = 3'd3,
    OP_ADV  = 3'd4
  } tmt_op_e;

  typedef struct packed {
    tmt_op_e            op;
    logic [RoundW-1:0]  round;
  } tmt_ctrl_t;

  // One state advance
  function automatic tmt_state_t tmt_advance(input tmt_state_t s,
                                             input logic [WordW-1:0] m1,
                                             input logic [WordW-1:0] m2);
    logic [WordW-1:0] x;
    logic [WordW-1:0] y;
    tmt_state_t       n;
    x = (s[0] & Low31) ^ s[1] ^ s[2];
    x = x ^ (x << Sh0);
    y = s[3] ^ (s[3] >> Sh0) ^ x;
    n[0] = s[1];
    n[1] = s[2];
    n[2] = x ^ (y << Sh1);
    n[3] = y;
    if (y[0]) begin
      n[1] = n[1] ^ m1;
      n[2] = n[2] ^ m2;
    end
    return n;
  endfunction

  // Output tempering
  function automatic logic [WordW-1:0] tmt_temper(input tmt_state_t s,
                                                  input logic [WordW-1:0] tm);
    logic [WordW-1:0] t1;
    logic [WordW-1:0] t0;
    t1 = s[0] + (s[2] >> Sh8);
    t0 = s[3] ^ t1;
    if (t1[0]) begin
      t0 = t0 ^ tm;
    end
    return t0;
  endfunction

endpackage

>>> hw/rtl/tmt_dp.sv
module tmt_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tmt_pkg::tmt_ctrl_t            ctrl_i,
  input  logic [tmt_pkg::WordW-1:0]     seed_i,
  input  logic [tmt_pkg::WordW-1:0]     mask_one_i,
  input  logic [tmt_pkg::WordW-1:0]     mask_two_i,
  input  logic [tmt_pkg::WordW-1:0]     temper_mask_i,
  output logic [tmt_pkg::WordW-1:0]     tempered_o
);

  tmt_pkg::tmt_state_t           state_q, state_d;
  logic [tmt_pkg::WordW-1:0]     product_q, product_d;
  logic [tmt_pkg::WordW-1:0]     mix_src;
  logic [1:0]                    prev_idx;
  logic [1:0]                    tgt_idx;

  assign tgt_idx  = ctrl_i.round[1:0];
  assign prev_idx = ctrl_i.round[1:0] - 2'd1;

  // Shared multiplier: one mixing product per round
  always_comb begin
    mix_src   = state_q[prev_idx] ^ (state_q[prev_idx] >> 30);
    product_d = 32'(tmt_pkg::MixMult * mix_src);
  end

  // State update
  always_comb begin
    state_d = state_q;
    case (ctrl_i.op)
      tmt_pkg::OP_LOAD: begin
        state_d[0] = seed_i;
        state_d[1] = mask_one_i;
        state_d[2] = mask_two_i;
        state_d[3] = temper_mask_i;
      end
      tmt_pkg::OP_MIX: begin
        state_d[tgt_idx] = state_q[tgt_idx]
                           ^ ({{(tmt_pkg::WordW-tmt_pkg::RoundW){1'b0}}, ctrl_i.round}
                              + product_q);
      end
      tmt_pkg::OP_ADV: begin
        state_d = tmt_pkg::tmt_advance(state_q, mask_one_i, mask_two_i);
      end
      default: begin
        state_d = state_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  // Product register, no reset needed
  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == tmt_pkg::OP_MUL) begin
      product_q <= product_d;
    end
  end

  assign tempered_o = tmt_pkg::tmt_temper(state_q, temper_mask_i);

endmodule

>>> hw/rtl/tinymt32_prng.sv
// TinyMT32 pseudo-random generator, 127-bit state in four 32-bit words.
// Input channel (in_valid_i / in_stall_o): kind_i = 0 reseeds from
// seed_value_i and returns nothing; kind_i = 1 advances the state once and
// returns one tempered word on the output channel (out_valid_o /
// out_stall_i, random_word_o). An item is taken at an edge with valid high
// and stall low.
// One item is worked at a time; in_stall_o is high until it is done.
// Generate: accept, one advance step, one tempering step; the word is
// loaded into the output register as the tempering step ends, and the
// next item is taken only after that, once the generator is back in idle.
// Reseed: load, seven mixing rounds of two steps each through the shared
// 32x32 multiplier (multiply, then add and xor), then eight advances,
// after which the next item can be taken.
// The config port (cfg_we_i, cfg_idx_i, cfg_wdata_i) writes the two
// transition masks and the tempering mask; write only while idle.
// Reset (rst_ni low, async) zeroes the state and loads the default masks;
// a generate before any reseed yields 0.
// A stalled output holds its word; a finished word waits in the tempering
// step until the output register is free.
module tinymt32_prng (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       kind_i,
  input  logic [tmt_pkg::WordW-1:0]  seed_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [tmt_pkg::WordW-1:0]  random_word_o,
  input  logic                       cfg_we_i,
  input  logic [tmt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tmt_pkg::WordW-1:0]  cfg_wdata_i
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL    = 5'b00010,
    ST_MIX    = 5'b00100,
    ST_ADV    = 5'b01000,
    ST_TEMPER = 5'b10000
  } state_e;

  state_e                        state_q, state_d;
  logic [tmt_pkg::RoundW-1:0]    round_q, round_d;
  logic [tmt_pkg::RoundW-1:0]    adv_cnt_q, adv_cnt_d;
  logic                          gen_q, gen_d;
  logic                          out_valid_q, out_valid_d;
  logic [tmt_pkg::WordW-1:0]     out_word_q;
  logic                          out_load;
  logic [tmt_pkg::WordW-1:0]     mask_one_q, mask_two_q, temper_mask_q;
  logic [tmt_pkg::WordW-1:0]     tempered;
  logic                          in_acc;
  tmt_pkg::tmt_ctrl_t            ctrl;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_one_q    <= tmt_pkg::MaskOneRst;
      mask_two_q    <= tmt_pkg::MaskTwoRst;
      temper_mask_q <= tmt_pkg::TempRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tmt_pkg::CfgMaskOne: mask_one_q    <= cfg_wdata_i;
        tmt_pkg::CfgMaskTwo: mask_two_q    <= cfg_wdata_i;
        tmt_pkg::CfgTemper:  temper_mask_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    round_d    = round_q;
    adv_cnt_d  = adv_cnt_q;
    gen_d      = gen_q;
    out_load   = 1'b0;
    ctrl.op    = tmt_pkg::OP_NONE;
    ctrl.round = round_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          adv_cnt_d = '0;
          if (kind_i == tmt_pkg::KindReseed) begin
            ctrl.op = tmt_pkg::OP_LOAD;
            round_d = 3'd1;
            gen_d   = 1'b0;
            state_d = ST_MUL;
          end else begin
            gen_d   = 1'b1;
            state_d = ST_ADV;
          end
        end
      end
      ST_MUL: begin
        ctrl.op = tmt_pkg::OP_MUL;
        state_d = ST_MIX;
      end
      ST_MIX: begin
        ctrl.op = tmt_pkg::OP_MIX;
        if (round_q == tmt_pkg::MixLast) begin
          adv_cnt_d = '0;
          state_d   = ST_ADV;
        end else begin
          round_d = round_q + 3'd1;
          state_d = ST_MUL;
        end
      end
      ST_ADV: begin
        ctrl.op = tmt_pkg::OP_ADV;
        if (gen_q) begin
          state_d = ST_TEMPER;
        end else if (adv_cnt_q == tmt_pkg::PreLast) begin
          state_d = ST_IDLE;
        end else begin
          adv_cnt_d = adv_cnt_q + 3'd1;
        end
      end
      ST_TEMPER: begin
        // wait for a free output register
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      round_q   <= '0;
      adv_cnt_q <= '0;
      gen_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      round_q   <= round_d;
      adv_cnt_q <= adv_cnt_d;
      gen_q     <= gen_d;
    end
  end

  tmt_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .seed_i        (seed_value_i),
    .mask_one_i    (mask_one_q),
    .mask_two_i    (mask_two_q),
    .temper_mask_i (temper_mask_q),
    .tempered_o    (tempered)
  );

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_word_q <= tempered;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign random_word_o = out_word_q;

`ifndef SYNTHESIS
  // A new word only ever comes out of the tempering step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_TEMPER))
    else $error("output valid rose outside tempering");

  // A reseed goes straight to the first multiply
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && kind_i == tmt_pkg::KindReseed) |=> (state_q == ST_MUL && round_q == 3'd1))
    else $error("reseed did not start mixing");

  // Mixing rounds stay in 1..7
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL || state_q == ST_MIX) |-> (round_q != '0))
    else $error("mixing round out of range");

  // Last mixing round hands over to the first advance of the reseed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MIX && round_q == tmt_pkg::MixLast)
      |=> (state_q == ST_ADV && adv_cnt_q == '0 && !gen_q))
    else $error("bad handover from mixing to advances");

  // A generate advances exactly once before tempering
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && kind_i == tmt_pkg::KindGenerate) |=> ##1 (state_q == ST_TEMPER))
    else $error("generate did not reach tempering");
`endif

endmodule
